// File: rtl/core/cbp_pkg.sv
// shared types, constants and arithmetic helpers for the beamformer
package cbp_pkg;

	localparam int ANT_W   = 6;
	localparam int BEAM_W  = 6;
	localparam int CHAN_W  = 4;
	localparam int SAMP_W  = 16;
	localparam int PROD_W  = 32;
	localparam int TERM_W  = 33;
	localparam int ACC_W   = 40;
	localparam int VAL_W   = 24;
	localparam int SQ_W    = 47;
	localparam int PAIR_W  = 48;
	localparam int POW_W   = 49;
	localparam int IDX_W   = 6;
	localparam int TDATA_W = 56;
	localparam int RES_W   = IDX_W + POW_W + 1;
	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 8;

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_SAMPLE = 2'd1,
		CMD_FLUSH  = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                kind;
		logic [ANT_W-1:0]         ant;
		logic                     pol;
		logic [BEAM_W-1:0]        beam;
		logic [CHAN_W-1:0]        chan;
		logic signed [SAMP_W-1:0] re;
		logic signed [SAMP_W-1:0] im;
		logic                     last;
	} cmd_t;

	localparam int CMD_W = $bits(cmd_t);

	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] s);
		logic signed [ACC_W-1:0] r;
		if (s[ACC_W] != s[ACC_W-1]) begin
			r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			r = s[ACC_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [VAL_W-1:0] scale_sat(input logic signed [ACC_W-1:0] v);
		logic signed [VAL_W:0]   t;
		logic signed [VAL_W-1:0] r;
		t = v[ACC_W-1:15];
		if (t[VAL_W] != t[VAL_W-1]) begin
			r = t[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		end else begin
			r = t[VAL_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/core/complex_beamformer_power.sv
// top level of the phase-shift beamformer with beam power output
// A weight write (tuser 0) goes to the weight store as it leaves the command queue. A sample
// (tuser 1) runs one complex multiply-accumulate per beam through the single read port of the
// weight store and one of the two read ports of the accumulator store, then a pipeline drain; a
// sample marked tlast then streams BEAMS power results, one per cycle while the output queue has
// room. A 4-entry command queue lets the input side keep accepting during that work. Reading a
// weight that was never written gives an undefined result.
module complex_beamformer_power import cbp_pkg::*; #(
	parameter int ANTENNAS = 64,
	parameter int BEAMS    = 64,
	parameter int CHANNELS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,  // antenna, polarization, beam, channel, value_re, value_im
	input  logic               s_tuser,  // mode
	input  logic               s_tlast,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,  // beam_index, beam_power
	output logic               m_tlast
);

	cmd_t             cmd_in, cmd_out;
	logic             cmd_push, cmd_full, cmd_empty, cmd_pop;
	logic [CMD_W-1:0] cmd_raw;
	logic             res_push, res_full, res_empty, res_taken;
	logic [RES_W-1:0] res_in, res_out;

	cbp_front #(
		.ANTENNAS(ANTENNAS), .BEAMS(BEAMS), .CHANNELS(CHANNELS)
	) u_front (
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.cmd_full(cmd_full), .cmd_push(cmd_push), .cmd(cmd_in)
	);

	cbp_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(cmd_push), .push_data(cmd_in), .full(cmd_full),
		.pop(cmd_pop), .pop_data(cmd_raw), .empty(cmd_empty)
	);

	assign cmd_out = cmd_t'(cmd_raw);

	cbp_back #(
		.ANTENNAS(ANTENNAS), .BEAMS(BEAMS), .CHANNELS(CHANNELS)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(!cmd_empty), .cmd(cmd_out), .cmd_pop(cmd_pop),
		.res_push(res_push), .res_data(res_in), .res_taken(res_taken)
	);

	cbp_fifo #(.WIDTH(RES_W), .DEPTH(OUT_DEPTH)) u_out_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(res_push), .push_data(res_in), .full(res_full),
		.pop(m_tready), .pop_data(res_out), .empty(res_empty)
	);

	assign m_tvalid  = !res_empty;
	assign res_taken = m_tvalid && m_tready;
	assign m_tdata   = {{(TDATA_W-IDX_W-POW_W){1'b0}}, res_out[IDX_W+POW_W-1:0]};
	assign m_tlast   = res_out[RES_W-1] & !res_full | res_out[RES_W-1];

endmodule

// File: rtl/core/cbp_fifo.sv
// small first-in first-out queue in registers
module cbp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [PW:0]      cnt_q;

	assign full     = (cnt_q == (PW+1)'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_q <= (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
		end
	end

endmodule

// File: rtl/core/cbp_front.sv
// input side: unpacks and classifies transactions into commands
module cbp_front import cbp_pkg::*; #(
	parameter int ANTENNAS = 64,
	parameter int BEAMS    = 64,
	parameter int CHANNELS = 16
) (
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,
	input  logic               s_tuser,
	input  logic               s_tlast,
	input  logic               cmd_full,
	output logic               cmd_push,
	output cmd_t               cmd
);

	logic ant_ok, beam_ok, chan_ok, keep;

	always_comb begin
		cmd.ant  = s_tdata[5:0];
		cmd.pol  = s_tdata[6];
		cmd.beam = s_tdata[12:7];
		cmd.chan = s_tdata[16:13];
		cmd.re   = s_tdata[32:17];
		cmd.im   = s_tdata[48:33];
		cmd.last = s_tlast;
		ant_ok   = (32'(cmd.ant) < ANTENNAS);
		beam_ok  = (32'(cmd.beam) < BEAMS);
		chan_ok  = (32'(cmd.chan) < CHANNELS);
		keep     = 1'b0;
		cmd.kind = CMD_FLUSH;
		if (!s_tuser) begin
			cmd.kind = CMD_WRITE;
			keep     = ant_ok && beam_ok && chan_ok;
		end else if (ant_ok && chan_ok) begin
			cmd.kind = CMD_SAMPLE;
			keep     = 1'b1;
		end else begin
			cmd.kind = CMD_FLUSH;
			keep     = s_tlast;
		end
	end

	assign s_tready = !cmd_full;
	assign cmd_push = s_tvalid && s_tready && keep;

endmodule

// File: rtl/core/cbp_back.sv
// execution side: weight store, per-beam accumulation and power readout
module cbp_back import cbp_pkg::*; #(
	parameter int ANTENNAS = 64,
	parameter int BEAMS    = 64,
	parameter int CHANNELS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  cmd_t             cmd,
	output logic             cmd_pop,
	output logic             res_push,
	output logic [RES_W-1:0] res_data,
	input  logic             res_taken
);

	localparam int AW  = (ANTENNAS > 1) ? $clog2(ANTENNAS) : 1;
	localparam int BW  = (BEAMS > 1) ? $clog2(BEAMS) : 1;
	localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int WAW = CW + BW + 1 + AW;
	localparam int KW  = BW + 1;
	localparam int CRW = $clog2(OUT_DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_MAC   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_POWER = 4'b1000
	} state_t;

	state_t state_q;
	logic [BW-1:0]  cnt_q;
	logic [1:0]     drain_q;
	logic           last_q;
	logic [CRW-1:0] credit_q;
	logic [AW-1:0]  ant_q;
	logic [CW-1:0]  chan_q;
	logic           pol_q;
	logic signed [SAMP_W-1:0] re_q, im_q;

	logic [31:0]         wmem [0:(1<<WAW)-1];
	logic [2*ACC_W-1:0]  amem [0:(1<<KW)-1];
	logic [(1<<KW)-1:0]  valid_q;

	logic issue_mac, issue_pow, clear_all, wr_en, last_beam;
	logic [WAW-1:0] wr_addr, rd_addr;
	logic [KW-1:0]  ka, kb;

	logic [31:0]        wrd_s1;
	logic [2*ACC_W-1:0] ra_s1, rb_s1;
	logic               va_s1, vb_s1, mac_s1, pow_s1;
	logic [KW-1:0]      k_s1;
	logic [BW-1:0]      idx_s1;

	logic signed [ACC_W-1:0] acc_re_s1, acc_im_s1, yre_s1, yim_s1;

	logic                     mac_s2, mac_s3;
	logic [KW-1:0]            k_s2, k_s3;
	logic signed [PROD_W-1:0] prr_s2, pii_s2, pri_s2, pir_s2;
	logic signed [ACC_W-1:0]  acc_re_s2, acc_im_s2, acc_re_s3, acc_im_s3;
	logic signed [TERM_W-1:0] pre_s3, pim_s3;
	logic signed [ACC_W:0]    nre, nim;

	logic                    pow_s2, pow_s3, pow_s4, pow_s5;
	logic [BW-1:0]           idx_s2, idx_s3, idx_s4, idx_s5;
	logic signed [VAL_W-1:0] xr_s2, xi_s2, yr_s2, yi_s2;
	logic [SQ_W-1:0]         sxr_s3, sxi_s3, syr_s3, syi_s3;
	logic [PAIR_W-1:0]       px_s4, py_s4;
	logic [POW_W-1:0]        pw_s5;

	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid;
	assign wr_en     = cmd_pop && (cmd.kind == CMD_WRITE);
	assign wr_addr   = {CW'(cmd.chan), BW'(cmd.beam), cmd.pol, AW'(cmd.ant)};
	assign rd_addr   = {chan_q, cnt_q, pol_q, ant_q};
	assign issue_mac = (state_q == ST_MAC);
	assign issue_pow = (state_q == ST_POWER) && (credit_q != '0);
	assign last_beam = (cnt_q == BW'(BEAMS - 1));
	assign clear_all = issue_pow && last_beam;
	assign ka        = issue_mac ? {pol_q, cnt_q} : {1'b0, cnt_q};
	assign kb        = {1'b1, cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			drain_q <= '0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.kind)
							CMD_SAMPLE: begin
								last_q  <= cmd.last;
								cnt_q   <= '0;
								state_q <= ST_MAC;
							end
							CMD_FLUSH: begin
								last_q  <= 1'b1;
								drain_q <= '0;
								state_q <= ST_DRAIN;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_MAC: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_beam) begin
						drain_q <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (drain_q == 2'd2) begin
						cnt_q   <= '0;
						state_q <= last_q ? ST_POWER : ST_IDLE;
					end
				end
				ST_POWER: begin
					if (issue_pow) begin
						cnt_q <= cnt_q + 1'b1;
						if (last_beam) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			ant_q  <= AW'(cmd.ant);
			chan_q <= CW'(cmd.chan);
			pol_q  <= cmd.pol;
			re_q   <= cmd.re;
			im_q   <= cmd.im;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= CRW'(OUT_DEPTH);
		end else begin
			credit_q <= credit_q - CRW'(issue_pow) + CRW'(res_taken);
		end
	end

	// weight store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			wmem[wr_addr] <= {cmd.im, cmd.re};
		end
		wrd_s1 <= wmem[rd_addr];
	end

	// accumulator store, one write and two reads
	always_ff @(posedge clk) begin
		if (mac_s3) begin
			amem[k_s3] <= {sat_acc(nim), sat_acc(nre)};
		end
		ra_s1 <= amem[ka];
		rb_s1 <= amem[kb];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear_all) begin
			valid_q <= '0;
		end else if (mac_s3) begin
			valid_q[k_s3] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1 <= 1'b0;
			mac_s2 <= 1'b0;
			mac_s3 <= 1'b0;
			pow_s1 <= 1'b0;
			pow_s2 <= 1'b0;
			pow_s3 <= 1'b0;
			pow_s4 <= 1'b0;
			pow_s5 <= 1'b0;
		end else begin
			mac_s1 <= issue_mac;
			mac_s2 <= mac_s1;
			mac_s3 <= mac_s2;
			pow_s1 <= issue_pow;
			pow_s2 <= pow_s1;
			pow_s3 <= pow_s2;
			pow_s4 <= pow_s3;
			pow_s5 <= pow_s4;
		end
	end

	assign acc_re_s1 = va_s1 ? ra_s1[ACC_W-1:0] : '0;
	assign acc_im_s1 = va_s1 ? ra_s1[2*ACC_W-1:ACC_W] : '0;
	assign yre_s1    = vb_s1 ? rb_s1[ACC_W-1:0] : '0;
	assign yim_s1    = vb_s1 ? rb_s1[2*ACC_W-1:ACC_W] : '0;

	assign nre = ACC_W'(0) + {acc_re_s3[ACC_W-1], acc_re_s3}
		+ {{(ACC_W+1-TERM_W){pre_s3[TERM_W-1]}}, pre_s3};
	assign nim = {acc_im_s3[ACC_W-1], acc_im_s3}
		+ {{(ACC_W+1-TERM_W){pim_s3[TERM_W-1]}}, pim_s3};

	always_ff @(posedge clk) begin
		va_s1  <= valid_q[ka];
		vb_s1  <= valid_q[kb];
		k_s1   <= ka;
		idx_s1 <= cnt_q;

		prr_s2    <= re_q * $signed(wrd_s1[15:0]);
		pii_s2    <= im_q * $signed(wrd_s1[31:16]);
		pri_s2    <= re_q * $signed(wrd_s1[31:16]);
		pir_s2    <= im_q * $signed(wrd_s1[15:0]);
		acc_re_s2 <= acc_re_s1;
		acc_im_s2 <= acc_im_s1;
		k_s2      <= k_s1;

		pre_s3    <= {prr_s2[PROD_W-1], prr_s2} + {pii_s2[PROD_W-1], pii_s2};
		pim_s3    <= {pri_s2[PROD_W-1], pri_s2} - {pir_s2[PROD_W-1], pir_s2};
		acc_re_s3 <= acc_re_s2;
		acc_im_s3 <= acc_im_s2;
		k_s3      <= k_s2;

		xr_s2  <= scale_sat(acc_re_s1);
		xi_s2  <= scale_sat(acc_im_s1);
		yr_s2  <= scale_sat(yre_s1);
		yi_s2  <= scale_sat(yim_s1);
		idx_s2 <= idx_s1;

		sxr_s3 <= SQ_W'(xr_s2 * xr_s2);
		sxi_s3 <= SQ_W'(xi_s2 * xi_s2);
		syr_s3 <= SQ_W'(yr_s2 * yr_s2);
		syi_s3 <= SQ_W'(yi_s2 * yi_s2);
		idx_s3 <= idx_s2;

		px_s4  <= PAIR_W'(sxr_s3) + PAIR_W'(sxi_s3);
		py_s4  <= PAIR_W'(syr_s3) + PAIR_W'(syi_s3);
		idx_s4 <= idx_s3;

		pw_s5  <= POW_W'(px_s4) + POW_W'(py_s4);
		idx_s5 <= idx_s4;
	end

	assign res_push = pow_s5;
	assign res_data = {(idx_s5 == BW'(BEAMS - 1)), pw_s5, IDX_W'(idx_s5)};

endmodule

// File: rtl/core/cbp_checker.sv
// port-level checks on the result stream, bound to the top level
module cbp_checker import cbp_pkg::*; #(
	parameter int BEAMS = 64
) (
	input logic               clk,
	input logic               arst_n,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic               m_tlast
);

	logic [IDX_W-1:0] exp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= '0;
		end else if (m_tvalid && m_tready) begin
			exp_q <= m_tlast ? '0 : exp_q + 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[IDX_W-1:0] == exp_q)
		else $error("beam results out of order");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tlast == (m_tdata[IDX_W-1:0] == IDX_W'(BEAMS - 1)))
		else $error("last mark not on final beam");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[IDX_W+POW_W-1:IDX_W] <= {1'b1, {(POW_W-1){1'b0}}})
		else $error("power above full scale");

endmodule

bind complex_beamformer_power cbp_checker #(.BEAMS(BEAMS)) u_cbp_checker (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tlast(m_tlast)
);
